// ----- design/ssi_pkg.sv -----
// shared types, widths and helper functions for the segment intersection pipeline
`timescale 1ns / 1ps

package ssi_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_W      = 32;
    localparam int WIDE_W     = 64;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int CROSS_W    = 2 * COORD_BITS + 3;
    localparam int MAG_W      = 2 * COORD_BITS + 2;
    localparam int PROD_W     = MAG_W + DIFF_W + FRAC_BITS;
    localparam int QUO_W      = COORD_BITS + FRAC_BITS + 2;

    localparam logic signed [WIDE_W-1:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [WIDE_W-1:0] SAT_LO = -64'sd2147483648;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]     t_diff;
    typedef logic signed [CROSS_W-1:0]    t_cross;
    typedef logic signed [OUT_W-1:0]      t_fix;

    typedef struct packed {
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by_coord;
        t_coord cx;
        t_coord cy;
        t_coord dx;
        t_coord dy;
    } t_in;

    typedef struct packed {
        logic [1:0] point_count;
        t_fix       first_x;
        t_fix       first_y;
        t_fix       second_x;
        t_fix       second_y;
    } t_out;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_CROSS,
        KIND_ONE,
        KIND_TWO
    } t_kind;

    // sideband that travels alongside the divider lanes
    typedef struct packed {
        t_kind  kind;
        logic   neg_x;
        logic   neg_y;
        t_coord base_x;
        t_coord base_y;
        t_coord p0x;
        t_coord p0y;
        t_coord p1x;
        t_coord p1y;
    } t_side;

    // one divider lane: partial remainder and dividend/quotient shift word
    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [QUO_W-1:0] word;
    } t_lane;

    function automatic t_diff diff(input t_coord a, input t_coord b);
        return t_diff'(a) - t_diff'(b);
    endfunction

    function automatic t_cross cross_prod(input t_diff ux, input t_diff uy,
                                          input t_diff vx, input t_diff vy);
        t_cross p;
        t_cross q;
        p = t_cross'(ux) * t_cross'(vy);
        q = t_cross'(vx) * t_cross'(uy);
        return p - q;
    endfunction

    function automatic logic spans(input t_coord a, input t_coord b,
                                   input t_coord c, input t_coord d);
        t_coord lo1;
        t_coord hi1;
        t_coord lo2;
        t_coord hi2;
        lo1 = (a > b) ? b : a;
        hi1 = (a > b) ? a : b;
        lo2 = (c > d) ? d : c;
        hi2 = (c > d) ? c : d;
        return (lo1 <= hi2) && (hi1 >= lo2);
    endfunction

    function automatic logic precedes(input t_coord x1, input t_coord y1,
                                      input t_coord x2, input t_coord y2);
        return (x1 < x2) || ((x1 == x2) && (y1 < y2));
    endfunction

    function automatic t_fix sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] c;
        c = v;
        if (v > SAT_HI) c = SAT_HI;
        if (v < SAT_LO) c = SAT_LO;
        return c[OUT_W-1:0];
    endfunction

    function automatic t_fix fixc(input t_coord v);
        logic signed [WIDE_W-1:0] w;
        w = WIDE_W'(v);
        return sat32(w <<< FRAC_BITS);
    endfunction

    // one restoring division step
    function automatic t_lane div_step(input t_lane l, input logic [MAG_W-1:0] dv);
        logic [MAG_W:0] t;
        logic           qb;
        t_lane          r;
        t  = {l.rem, l.word[QUO_W-1]};
        qb = 1'b0;
        if (t >= {1'b0, dv}) begin
            t  = t - {1'b0, dv};
            qb = 1'b1;
        end
        r.rem  = t[MAG_W-1:0];
        r.word = {l.word[QUO_W-2:0], qb};
        return r;
    endfunction

endpackage

// ----- design/ssi_front.sv -----
// front stages: differences, cross products, classification and product terms
`timescale 1ns / 1ps

module ssi_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  ssi_pkg::t_in               i_data,
    output logic                       o_valid,
    output ssi_pkg::t_side             o_side,
    output logic [ssi_pkg::PROD_W-1:0] o_px,
    output logic [ssi_pkg::PROD_W-1:0] o_py,
    output logic [ssi_pkg::MAG_W-1:0]  o_dv
);
    import ssi_pkg::*;

    // stage a: bounding box and coordinate differences
    logic  r_a_vld, r_a_pass;
    t_in   r_a_pt;
    t_diff r_a_bax, r_a_bay, r_a_cax, r_a_cay, r_a_dax, r_a_day;
    t_diff r_a_dcx, r_a_dcy, r_a_bcx, r_a_bcy, r_a_acx, r_a_acy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
        end
        if (i_en) begin
            r_a_pass <= spans(i_data.ax, i_data.bx, i_data.cx, i_data.dx)
                     && spans(i_data.ay, i_data.by_coord, i_data.cy, i_data.dy);
            r_a_pt   <= i_data;
            r_a_bax  <= diff(i_data.bx, i_data.ax);
            r_a_bay  <= diff(i_data.by_coord, i_data.ay);
            r_a_cax  <= diff(i_data.cx, i_data.ax);
            r_a_cay  <= diff(i_data.cy, i_data.ay);
            r_a_dax  <= diff(i_data.dx, i_data.ax);
            r_a_day  <= diff(i_data.dy, i_data.ay);
            r_a_dcx  <= diff(i_data.dx, i_data.cx);
            r_a_dcy  <= diff(i_data.dy, i_data.cy);
            r_a_bcx  <= diff(i_data.bx, i_data.cx);
            r_a_bcy  <= diff(i_data.by_coord, i_data.cy);
            r_a_acx  <= diff(i_data.ax, i_data.cx);
            r_a_acy  <= diff(i_data.ay, i_data.cy);
        end
    end

    // stage b: cross products
    logic   r_b_vld, r_b_pass;
    t_in    r_b_pt;
    t_diff  r_b_bax, r_b_bay;
    t_cross r_b_k1, r_b_k2, r_b_k3, r_b_k4, r_b_den, r_b_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_a_vld;
        end
        if (i_en) begin
            r_b_pass <= r_a_pass;
            r_b_pt   <= r_a_pt;
            r_b_bax  <= r_a_bax;
            r_b_bay  <= r_a_bay;
            r_b_k1   <= cross_prod(r_a_bax, r_a_bay, r_a_cax, r_a_cay);
            r_b_k2   <= cross_prod(r_a_bax, r_a_bay, r_a_dax, r_a_day);
            r_b_k3   <= cross_prod(r_a_dcx, r_a_dcy, r_a_bcx, r_a_bcy);
            r_b_k4   <= cross_prod(r_a_dcx, r_a_dcy, r_a_acx, r_a_acy);
            r_b_den  <= cross_prod(r_a_bax, r_a_bay, r_a_dcx, r_a_dcy);
            r_b_num  <= cross_prod(r_a_cax, r_a_cay, r_a_dcx, r_a_dcy);
        end
    end

    // stage c: classification, overlap ends and magnitudes
    logic   coll, side_rej, den_zero;
    logic   swap1, swap2, low_from2, high_from1;
    t_coord l1x, l1y, h1x, h1y, l2x, l2y, h2x, h2y;
    t_side  n_c_side;
    logic [MAG_W-1:0]  n_c_mnum, n_c_mden;
    logic [DIFF_W-1:0] n_c_mbx, n_c_mby;

    always_comb begin
        coll     = (r_b_k1 == '0) && (r_b_k2 == '0) && (r_b_k3 == '0) && (r_b_k4 == '0);
        side_rej = ((r_b_k1 != '0) && (r_b_k2 != '0)
                    && (r_b_k1[CROSS_W-1] == r_b_k2[CROSS_W-1]))
                || ((r_b_k3 != '0) && (r_b_k4 != '0)
                    && (r_b_k3[CROSS_W-1] == r_b_k4[CROSS_W-1]));
        den_zero = (r_b_den == '0);

        // order each segment's ends, then clip to the shared piece
        swap1 = precedes(r_b_pt.bx, r_b_pt.by_coord, r_b_pt.ax, r_b_pt.ay);
        swap2 = precedes(r_b_pt.dx, r_b_pt.dy, r_b_pt.cx, r_b_pt.cy);
        l1x = swap1 ? r_b_pt.bx : r_b_pt.ax;
        l1y = swap1 ? r_b_pt.by_coord : r_b_pt.ay;
        h1x = swap1 ? r_b_pt.ax : r_b_pt.bx;
        h1y = swap1 ? r_b_pt.ay : r_b_pt.by_coord;
        l2x = swap2 ? r_b_pt.dx : r_b_pt.cx;
        l2y = swap2 ? r_b_pt.dy : r_b_pt.cy;
        h2x = swap2 ? r_b_pt.cx : r_b_pt.dx;
        h2y = swap2 ? r_b_pt.cy : r_b_pt.dy;
        low_from2  = precedes(l1x, l1y, l2x, l2y);
        high_from1 = precedes(h1x, h1y, h2x, h2y);

        n_c_side.p0x = low_from2 ? l2x : l1x;
        n_c_side.p0y = low_from2 ? l2y : l1y;
        n_c_side.p1x = high_from1 ? h1x : h2x;
        n_c_side.p1y = high_from1 ? h1y : h2y;
        n_c_side.base_x = r_b_pt.ax;
        n_c_side.base_y = r_b_pt.ay;

        if (!r_b_pass) begin
            n_c_side.kind = KIND_NONE;
        end else if (coll) begin
            if ((n_c_side.p0x == n_c_side.p1x) && (n_c_side.p0y == n_c_side.p1y)) begin
                n_c_side.kind = KIND_ONE;
            end else begin
                n_c_side.kind = KIND_TWO;
            end
        end else if (side_rej || den_zero) begin
            n_c_side.kind = KIND_NONE;
        end else begin
            n_c_side.kind = KIND_CROSS;
        end

        // sign of the floored offset
        n_c_side.neg_x = (r_b_num != '0) && (r_b_bax != '0)
                      && (r_b_num[CROSS_W-1] ^ r_b_bax[DIFF_W-1] ^ r_b_den[CROSS_W-1]);
        n_c_side.neg_y = (r_b_num != '0) && (r_b_bay != '0)
                      && (r_b_num[CROSS_W-1] ^ r_b_bay[DIFF_W-1] ^ r_b_den[CROSS_W-1]);

        n_c_mnum = r_b_num[CROSS_W-1] ? MAG_W'(-r_b_num) : MAG_W'(r_b_num);
        n_c_mden = r_b_den[CROSS_W-1] ? MAG_W'(-r_b_den) : MAG_W'(r_b_den);
        n_c_mbx  = r_b_bax[DIFF_W-1] ? DIFF_W'(-r_b_bax) : DIFF_W'(r_b_bax);
        n_c_mby  = r_b_bay[DIFF_W-1] ? DIFF_W'(-r_b_bay) : DIFF_W'(r_b_bay);
    end

    logic              r_c_vld;
    t_side             r_c_side;
    logic [MAG_W-1:0]  r_c_mnum, r_c_mden;
    logic [DIFF_W-1:0] r_c_mbx, r_c_mby;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_c_vld <= r_b_vld;
        end
        if (i_en) begin
            r_c_side <= n_c_side;
            r_c_mnum <= n_c_mnum;
            r_c_mden <= n_c_mden;
            r_c_mbx  <= n_c_mbx;
            r_c_mby  <= n_c_mby;
        end
    end

    // stage d: scaled dividends
    logic              r_d_vld;
    t_side             r_d_side;
    logic [PROD_W-1:0] r_d_px, r_d_py;
    logic [MAG_W-1:0]  r_d_dv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (i_en) begin
            r_d_vld <= r_c_vld;
        end
        if (i_en) begin
            r_d_side <= r_c_side;
            r_d_px   <= (PROD_W'(r_c_mnum) * PROD_W'(r_c_mbx)) << FRAC_BITS;
            r_d_py   <= (PROD_W'(r_c_mnum) * PROD_W'(r_c_mby)) << FRAC_BITS;
            r_d_dv   <= r_c_mden;
        end
    end

    assign o_valid = r_d_vld;
    assign o_side  = r_d_side;
    assign o_px    = r_d_px;
    assign o_py    = r_d_py;
    assign o_dv    = r_d_dv;

endmodule

// ----- design/ssi_divider.sv -----
// pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor
`timescale 1ns / 1ps

module ssi_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  ssi_pkg::t_side             i_side,
    input  logic [ssi_pkg::PROD_W-1:0] i_px,
    input  logic [ssi_pkg::PROD_W-1:0] i_py,
    input  logic [ssi_pkg::MAG_W-1:0]  i_dv,
    output logic                       o_valid,
    output ssi_pkg::t_side             o_side,
    output ssi_pkg::t_lane             o_lx,
    output ssi_pkg::t_lane             o_ly
);
    import ssi_pkg::*;

    logic             r_vld  [QUO_W];
    t_side            r_side [QUO_W];
    logic [MAG_W-1:0] r_dv   [QUO_W];
    t_lane            r_lx   [QUO_W];
    t_lane            r_ly   [QUO_W];

    t_lane init_x, init_y;

    // upper dividend bits give a remainder already below the divisor
    always_comb begin
        init_x.rem  = MAG_W'(i_px[PROD_W-1:QUO_W]);
        init_x.word = i_px[QUO_W-1:0];
        init_y.rem  = MAG_W'(i_py[PROD_W-1:QUO_W]);
        init_y.word = i_py[QUO_W-1:0];
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QUO_W; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < QUO_W; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // division steps
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_dv[0]   <= i_dv;
            r_lx[0]   <= div_step(init_x, i_dv);
            r_ly[0]   <= div_step(init_y, i_dv);
            for (int k = 1; k < QUO_W; k++) begin
                r_side[k] <= r_side[k-1];
                r_dv[k]   <= r_dv[k-1];
                r_lx[k]   <= div_step(r_lx[k-1], r_dv[k-1]);
                r_ly[k]   <= div_step(r_ly[k-1], r_dv[k-1]);
            end
        end
    end

    assign o_valid = r_vld[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];
    assign o_lx    = r_lx[QUO_W-1];
    assign o_ly    = r_ly[QUO_W-1];

endmodule

// ----- design/ssi_finish.sv -----
// final stage: floor, offset from the start point, saturation and result register
`timescale 1ns / 1ps

module ssi_finish (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  ssi_pkg::t_side i_side,
    input  ssi_pkg::t_lane i_lx,
    input  ssi_pkg::t_lane i_ly,
    output logic           o_valid,
    output ssi_pkg::t_out  o_data
);
    import ssi_pkg::*;

    function automatic t_fix place(input t_coord base, input t_lane l, input logic neg);
        logic signed [WIDE_W-1:0] q;
        logic signed [WIDE_W-1:0] off;
        logic signed [WIDE_W-1:0] b;
        q   = WIDE_W'(l.word);
        off = neg ? (-q - ((l.rem != '0) ? 64'sd1 : 64'sd0)) : q;
        b   = WIDE_W'(base);
        return sat32((b <<< FRAC_BITS) + off);
    endfunction

    t_out n_out;

    // result selection
    always_comb begin
        n_out = '0;
        case (i_side.kind)
            KIND_CROSS: begin
                n_out.point_count = 2'd1;
                n_out.first_x     = place(i_side.base_x, i_lx, i_side.neg_x);
                n_out.first_y     = place(i_side.base_y, i_ly, i_side.neg_y);
            end
            KIND_ONE: begin
                n_out.point_count = 2'd1;
                n_out.first_x     = fixc(i_side.p0x);
                n_out.first_y     = fixc(i_side.p0y);
            end
            KIND_TWO: begin
                n_out.point_count = 2'd2;
                n_out.first_x     = fixc(i_side.p0x);
                n_out.first_y     = fixc(i_side.p0y);
                n_out.second_x    = fixc(i_side.p1x);
                n_out.second_y    = fixc(i_side.p1y);
            end
            default: n_out = '0;
        endcase
    end

    logic r_vld;
    t_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_out;

endmodule

// ----- design/segment_segment_intersection.sv -----
// Segment pair intersection, fully pipelined.
// Pipeline: four setup stages, one divider stage per quotient bit, one output stage.
// Throughput: one pair per cycle while no finished result is held back by i_stall;
//   the restoring divider chain sets the depth.
// Reset: synchronous active-low reset clears every valid bit; data registers are not reset.
`timescale 1ns / 1ps

module segment_segment_intersection (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  ssi_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output ssi_pkg::t_out o_data
);
    import ssi_pkg::*;

    // whole pipeline advances unless a finished result is held back
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    logic              f_vld;
    t_side             f_side;
    logic [PROD_W-1:0] f_px, f_py;
    logic [MAG_W-1:0]  f_dv;

    ssi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_valid (f_vld),
        .o_side  (f_side),
        .o_px    (f_px),
        .o_py    (f_py),
        .o_dv    (f_dv)
    );

    logic  d_vld;
    t_side d_side;
    t_lane d_lx, d_ly;

    ssi_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_vld),
        .i_side  (f_side),
        .i_px    (f_px),
        .i_py    (f_py),
        .i_dv    (f_dv),
        .o_valid (d_vld),
        .o_side  (d_side),
        .o_lx    (d_lx),
        .o_ly    (d_ly)
    );

    ssi_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d_vld),
        .i_side  (d_side),
        .i_lx    (d_lx),
        .i_ly    (d_ly),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

`ifndef ASSERT_OFF
    // back-pressure only comes from a waiting result
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall raised with no result waiting");

    // point count never takes the unused code
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.point_count != 2'd3))
        else $error("point count out of range");

    // absent points are zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.point_count == 2'd0))
        |-> ((o_data.first_x == '0) && (o_data.first_y == '0)))
        else $error("first point not zero with no points");

    a_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.point_count != 2'd2))
        |-> ((o_data.second_x == '0) && (o_data.second_y == '0)))
        else $error("second point not zero without overlap");
`endif

endmodule
